FILE: src/xkrd_pkg.sv
// shared types, constants and defaults for the xor keyed record deframer
package xkrd_pkg;

  // widest length field the block supports, in bytes
  localparam int LEN_BYTES_MAX = 8;
  localparam int LEN_W         = 8 * LEN_BYTES_MAX;
  localparam int CNT_W         = $clog2(LEN_BYTES_MAX + 1);

  // defaults for the length field sizes
  localparam int PATH_LEN_BYTES_DEF    = 8;
  localparam int CONTENT_LEN_BYTES_DEF = 8;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_PATH    = 2'd0,
    KIND_CONTENT = 2'd1,
    KIND_CLEN    = 2'd2,
    KIND_STATUS  = 2'd3
  } kind_t;

  // one result word as it leaves the parser
  typedef struct packed {
    logic             have;
    kind_t            kind;
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] content_length;
    logic             record_last;
    logic             truncated;
  } result_t;

endpackage

FILE: src/xor_keyed_record_deframer_top.sv
// Byte-stream deframer for xor keyed records. Takes one package byte per cycle
// on the in_valid/in_ready channel and gives at most one result word per byte
// on the out_valid/out_ready channel, in the cycle after the byte is accepted.
// Each record is a plain key byte, a big-endian path length, the path, a
// big-endian content length and the content, all after the key xored with it.
// Path and content bytes come out descrambled, the content length comes out
// once its field is complete, and the last word of a record carries
// record_last. A package ending inside a record gives truncated, with a
// status-only word when its final byte would otherwise give none. Key and
// length bytes give no word, bar the last content length byte. One output
// register separates the sides: a byte is taken in every cycle while results
// drain. The parser step is xor, 64-bit shift, decrement and compare.
module xor_keyed_record_deframer_top #(
  parameter int PATH_LEN_BYTES    = xkrd_pkg::PATH_LEN_BYTES_DEF,
  parameter int CONTENT_LEN_BYTES = xkrd_pkg::CONTENT_LEN_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_package,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [63:0] content_length,
  output logic        record_last,
  output logic        truncated
);

  logic              accept;
  xkrd_pkg::result_t result;
  xkrd_pkg::result_t held;

  assign accept = in_valid & in_ready;

  // parser
  xkrd_parse #(
    .PATH_LEN_BYTES    (PATH_LEN_BYTES),
    .CONTENT_LEN_BYTES (CONTENT_LEN_BYTES)
  ) u_parse (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .in_byte        (in_byte),
    .end_of_package (end_of_package),
    .result         (result)
  );

  // output register
  xkrd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .result    (result),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign kind           = held.kind;
  assign out_byte       = held.out_byte;
  assign content_length = held.content_length;
  assign record_last    = held.record_last;
  assign truncated      = held.truncated;

endmodule

FILE: src/xkrd_parse.sv
// record parser: key capture, length gathering, descrambling and end detection
module xkrd_parse #(
  parameter int PATH_LEN_BYTES    = xkrd_pkg::PATH_LEN_BYTES_DEF,
  parameter int CONTENT_LEN_BYTES = xkrd_pkg::CONTENT_LEN_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              end_of_package,
  output xkrd_pkg::result_t result
);

  typedef enum logic [2:0] {
    PH_KEY  = 3'd0,
    PH_PLEN = 3'd1,
    PH_PATH = 3'd2,
    PH_CLEN = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  localparam logic [xkrd_pkg::CNT_W-1:0] PLEN_LAST = xkrd_pkg::CNT_W'(PATH_LEN_BYTES);
  localparam logic [xkrd_pkg::CNT_W-1:0] CLEN_LAST = xkrd_pkg::CNT_W'(CONTENT_LEN_BYTES);
  localparam logic [xkrd_pkg::LEN_W-1:0] REM_ONE   = xkrd_pkg::LEN_W'(1);

  phase_t                        phase, phase_next;
  logic [7:0]                    record_key, record_key_next;
  logic [xkrd_pkg::CNT_W-1:0]    field_byte_count, field_byte_count_next;
  logic [xkrd_pkg::LEN_W-1:0]    length_shift, length_shift_next;
  logic [xkrd_pkg::LEN_W-1:0]    bytes_remaining, bytes_remaining_next;

  logic [7:0]                    plain;
  logic [xkrd_pkg::LEN_W-1:0]    shifted;
  logic [xkrd_pkg::CNT_W-1:0]    cnt_inc;
  logic                          rem_last;
  logic                          done;

  assign plain    = in_byte ^ record_key;
  assign shifted  = {length_shift[xkrd_pkg::LEN_W-9:0], plain};
  assign cnt_inc  = field_byte_count + xkrd_pkg::CNT_W'(1);
  assign rem_last = (bytes_remaining == REM_ONE);

  // next state and result for the word on the input
  always_comb begin
    phase_next            = phase;
    record_key_next       = record_key;
    field_byte_count_next = field_byte_count;
    length_shift_next     = length_shift;
    bytes_remaining_next  = bytes_remaining;
    done                  = 1'b0;
    result                = '0;
    result.kind           = xkrd_pkg::KIND_STATUS;

    case (phase)
      PH_KEY: begin
        record_key_next       = in_byte;
        phase_next            = PH_PLEN;
        field_byte_count_next = '0;
        length_shift_next     = '0;
      end
      PH_PLEN: begin
        length_shift_next     = shifted;
        field_byte_count_next = cnt_inc;
        if (cnt_inc >= PLEN_LAST) begin
          bytes_remaining_next  = shifted;
          field_byte_count_next = '0;
          length_shift_next     = '0;
          phase_next            = (shifted == '0) ? PH_CLEN : PH_PATH;
        end
      end
      PH_PATH: begin
        result.have          = 1'b1;
        result.kind          = xkrd_pkg::KIND_PATH;
        result.out_byte      = plain;
        bytes_remaining_next = bytes_remaining - REM_ONE;
        if (rem_last) begin
          field_byte_count_next = '0;
          length_shift_next     = '0;
          phase_next            = PH_CLEN;
        end
      end
      PH_CLEN: begin
        length_shift_next     = shifted;
        field_byte_count_next = cnt_inc;
        if (cnt_inc >= CLEN_LAST) begin
          result.have           = 1'b1;
          result.kind           = xkrd_pkg::KIND_CLEN;
          result.content_length = shifted;
          bytes_remaining_next  = shifted;
          field_byte_count_next = '0;
          length_shift_next     = '0;
          if (shifted == '0) begin
            done       = 1'b1;
            phase_next = PH_KEY;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        result.have          = 1'b1;
        result.kind          = xkrd_pkg::KIND_CONTENT;
        result.out_byte      = plain;
        bytes_remaining_next = bytes_remaining - REM_ONE;
        if (rem_last) begin
          done                 = 1'b1;
          phase_next           = PH_KEY;
          bytes_remaining_next = '0;
        end
      end
      default: begin
        phase_next            = PH_KEY;
        field_byte_count_next = '0;
        length_shift_next     = '0;
        bytes_remaining_next  = '0;
      end
    endcase

    result.record_last = done;

    // end of package: always report, back to waiting for a key
    if (end_of_package) begin
      result.have           = 1'b1;
      result.record_last    = 1'b1;
      result.truncated      = ~done;
      phase_next            = PH_KEY;
      field_byte_count_next = '0;
      length_shift_next     = '0;
      bytes_remaining_next  = '0;
    end
  end

  // parser state, advanced on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_KEY;
      record_key       <= '0;
      field_byte_count <= '0;
      length_shift     <= '0;
      bytes_remaining  <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      record_key       <= record_key_next;
      field_byte_count <= field_byte_count_next;
      length_shift     <= length_shift_next;
      bytes_remaining  <= bytes_remaining_next;
    end
  end

endmodule

FILE: src/xkrd_out_reg.sv
// result register holding one output word until it is taken
module xkrd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  xkrd_pkg::result_t result,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output xkrd_pkg::result_t held
);

  // free when empty or being emptied this cycle
  assign in_ready = ~out_valid | out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && result.have) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept && result.have) begin
      held <= result;
    end
  end

endmodule
